/* sv/ukc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the union-find clustering block.
// No dependencies; the sequencer, the top level and the testbench import this package.
package ukc_pkg;

    localparam int VERTEX_W    = 11;
    localparam int LENGTH_W    = 20;
    localparam int RANK_W      = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [RANK_W-1:0]   RANK_MAX      = 4'd15;
    localparam logic [LENGTH_W-1:0] SPACING_START = 20'd1000000;

    localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 11'd1024;
    localparam logic [VERTEX_W-1:0] TARGET_RESET       = 11'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CLUSTERS = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_DECIDE,
        ST_LINK2,
        ST_FINISH
    } seq_state_t;

    // Settings handed from the register bank to the sequencer
    typedef struct packed {
        logic                restart;
        logic [VERTEX_W-1:0] live_vertices;
        logic [VERTEX_W-1:0] target;
    } cfg_t;

    // One finished result
    typedef struct packed {
        logic [LENGTH_W-1:0] spacing;
        logic [VERTEX_W-1:0] clusters;
    } result_t;

endpackage

/* sv/ukc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ukc_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ukc_seq.sv */
`timescale 1ns / 1ps
// Edge sequencer: clearing pass, root walks, union by rank, spacing tracking.
// Depends on ukc_pkg and ukc_ram (holds the combined rank/parent store).
module ukc_seq #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ukc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ukc_pkg::VERTEX_W-1:0]  first_vertex,
    input  logic [ukc_pkg::VERTEX_W-1:0]  second_vertex,
    input  logic [ukc_pkg::LENGTH_W-1:0]  edge_length,
    input  logic                          last_edge,
    input  logic                          res_ready,
    output logic                          res_load,
    output ukc_pkg::result_t              res
);
    import ukc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int WW = VW + RANK_W;
    localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

    seq_state_t state_reg, state_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [VW-1:0]       vb_reg, vb_next;
    logic [VW-1:0]       root_a_reg, root_a_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [VW-1:0]       root_b_reg, root_b_next;
    logic [RANK_W-1:0]   rank_b_reg, rank_b_next;
    logic [LENGTH_W-1:0] len_reg, len_next;
    logic                last_reg, last_next;
    logic [VERTEX_W-1:0] count_reg, count_next;
    logic [LENGTH_W-1:0] spacing_reg, spacing_next;

    logic          ram_we;
    logic [VW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [VW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;
    logic [VW-1:0] rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic          accept;
    logic          in_range;

    ukc_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_parent = ram_rdata[VW-1:0];
    assign rd_rank   = ram_rdata[WW-1:VW];
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = (first_vertex != '0) && (first_vertex <= cfg.live_vertices)
                    && (second_vertex != '0) && (second_vertex <= cfg.live_vertices);
    assign res.spacing  = spacing_reg;
    assign res.clusters = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cur_reg     <= '0;
            count_reg   <= '0;
            spacing_reg <= SPACING_START;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            count_reg   <= count_next;
            spacing_reg <= spacing_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vb_reg     <= vb_next;
        root_a_reg <= root_a_next;
        rank_a_reg <= rank_a_next;
        root_b_reg <= root_b_next;
        rank_b_reg <= rank_b_next;
        len_reg    <= len_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        vb_next      = vb_reg;
        root_a_next  = root_a_reg;
        rank_a_next  = rank_a_reg;
        root_b_next  = root_b_reg;
        rank_b_next  = rank_b_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        spacing_next = spacing_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_reg;
        ram_wdata    = {{RANK_W{1'b0}}, cur_reg};
        ram_raddr    = rd_parent;
        res_load     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep identity parents and zero ranks, one entry a cycle
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {{RANK_W{1'b0}}, cur_reg};
                cur_next  = cur_reg + 1'b1;
                if (cur_reg == LAST_IDX)
                begin
                    count_next   = cfg.live_vertices;
                    spacing_next = SPACING_START;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = VW'(first_vertex - 1'b1);
                if (accept)
                begin
                    cur_next  = VW'(first_vertex - 1'b1);
                    vb_next   = VW'(second_vertex - 1'b1);
                    len_next  = edge_length;
                    last_next = last_edge;
                    state_next = in_range ? ST_WALK_A : ST_FINISH;
                end
            end
            ST_WALK_A:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_a_next = cur_reg;
                    rank_a_next = rd_rank;
                    ram_raddr   = vb_reg;
                    cur_next    = vb_reg;
                    state_next  = ST_WALK_B;
                end
                else
                begin
                    cur_next = rd_parent;
                end
            end
            ST_WALK_B:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_b_next = cur_reg;
                    rank_b_next = rd_rank;
                    state_next  = ST_DECIDE;
                end
                else
                begin
                    cur_next = rd_parent;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_FINISH;
                if (count_reg > cfg.target)
                begin
                    if (root_a_reg != root_b_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        ram_we     = 1'b1;
                        if (rank_a_reg < rank_b_reg)
                        begin
                            ram_waddr = root_a_reg;
                            ram_wdata = {rank_a_reg, root_b_reg};
                        end
                        else
                        begin
                            ram_waddr = root_b_reg;
                            ram_wdata = {rank_b_reg, root_a_reg};
                            if (rank_a_reg == rank_b_reg)
                            begin
                                state_next = ST_LINK2;
                            end
                        end
                    end
                end
                else if ((root_a_reg != root_b_reg) && (len_reg < spacing_reg))
                begin
                    spacing_next = len_reg;
                end
            end
            ST_LINK2:
            begin
                // Equal ranks: bump the surviving root's rank, saturating
                ram_we     = 1'b1;
                ram_waddr  = root_a_reg;
                ram_wdata  = {(rank_a_reg == RANK_MAX) ? rank_a_reg : rank_a_reg + 1'b1,
                              root_a_reg};
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (res_ready)
                begin
                    res_load   = 1'b1;
                    cur_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cur_next   = '0;
            end
        endcase

        // A new vertex count rebuilds the graph from scratch
        if (cfg.restart)
        begin
            state_next = ST_CLEAR;
            cur_next   = '0;
            res_load   = 1'b0;
        end
    end

endmodule

/* sv/union_find_kruskal_clustering_top.sv */
`timescale 1ns / 1ps
// Top level of the single-link clustering block: register bank, sequencer, result register.
// Depends on ukc_pkg, ukc_seq and ukc_ram.
//
// Usage:
//   Edges enter on the input channel (in_valid / in_stall) sorted by ascending length:
//   two 1-based vertex numbers, the length and a last-edge mark. An item is taken at a
//   clock edge with in_valid high and in_stall low. Only the item marked last produces a
//   result on the output channel (out_valid / out_stall): the minimum spacing between
//   clusters and the final cluster count.
//   Each edge is accepted, then its roots are found by walking parent links from the
//   first endpoint and then from the second, one link per cycle through the single
//   read port of the rank/parent RAM; then come a decide step, an extra step for an
//   equal-rank union, and a finish step. With union by rank a chain is at most
//   log2(vertex count) links long. Edges with an endpoint out of range skip the walk
//   and go straight to the finish step.
//   After reset, after each write of vertex_count and after each last edge the RAM is
//   swept back to identity parents and zero ranks; in_stall stays high during the
//   sweep. Configuration writes are taken at any time.
//   The result sits in an output register; the next graph's edges are accepted while it
//   waits. A last edge holds in the sequencer until that register is free.
module union_find_kruskal_clustering_top #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ukc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ukc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ukc_pkg::VERTEX_W-1:0]    first_vertex,
    input  logic [ukc_pkg::VERTEX_W-1:0]    second_vertex,
    input  logic [ukc_pkg::LENGTH_W-1:0]    edge_length,
    input  logic                            last_edge,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ukc_pkg::LENGTH_W-1:0]    max_spacing,
    output logic [ukc_pkg::VERTEX_W-1:0]    final_clusters
);
    import ukc_pkg::*;

    logic [VERTEX_W-1:0] vertex_count_reg;
    logic [VERTEX_W-1:0] target_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg;
    cfg_t                cfg;
    logic                res_ready;
    logic                res_load;
    result_t             res;

    // Register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
            target_reg       <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERTEX_COUNT:    vertex_count_reg <= cfg_data;
                REG_TARGET_CLUSTERS: target_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Clamp the vertex count to the store depth; a restart waits for the new value
    assign cfg.live_vertices = (32'(vertex_count_reg) > MAX_VERTICES)
                             ? VERTEX_W'(MAX_VERTICES) : vertex_count_reg;
    assign cfg.target  = target_reg;
    assign cfg.restart = cfg_we && (cfg_index == REG_VERTEX_COUNT);

    ukc_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .edge_length   (edge_length),
        .last_edge     (last_edge),
        .res_ready     (res_ready),
        .res_load      (res_load),
        .res           (res)
    );

    // Result register: free when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign max_spacing    = out_data_reg.spacing;
    assign final_clusters = out_data_reg.clusters;

endmodule

/* tb/sv/union_find_kruskal_clustering_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for union_find_kruskal_clustering_top: streams of mostly sorted
// edges in, one spacing/cluster report per graph out, checked against an in-bench forest model.
// Depends on ukc_pkg and the RTL of the block; reads no files.
module union_find_kruskal_clustering_top_tb;

    import ukc_pkg::*;

    // Same depth as the block's default MAX_VERTICES
    localparam int FOREST_SIZE  = 1024;
    // Wait after the last report before a register write or the end of the run:
    // the block sweeps its RAM after every last edge.
    localparam int SETTLE_CYCLES = 1200;
    // Long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 6000;
    localparam int CYCLE_LIMIT   = 5000000;

    // One edge of the graph, as it goes onto the input channel
    typedef struct packed {
        logic [VERTEX_W-1:0] u;
        logic [VERTEX_W-1:0] v;
        logic [LENGTH_W-1:0] len;
        logic                last;
    } edge_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [VERTEX_W-1:0]    first_vertex = '0;
    logic [VERTEX_W-1:0]    second_vertex = '0;
    logic [LENGTH_W-1:0]    edge_length = '0;
    logic                   last_edge = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LENGTH_W-1:0]    max_spacing;
    logic [VERTEX_W-1:0]    final_clusters;

    union_find_kruskal_clustering_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_vertex   (first_vertex),
        .second_vertex  (second_vertex),
        .edge_length    (edge_length),
        .last_edge      (last_edge),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .max_spacing    (max_spacing),
        .final_clusters (final_clusters)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Forest model: parent/rank per vertex, live cluster count, spacing.
    // Updated once per accepted edge, and on every vertex_count write.
    // ------------------------------------------------------------------
    logic [9:0]          uf_parent [FOREST_SIZE];
    logic [RANK_W-1:0]   uf_rank   [FOREST_SIZE];
    logic [VERTEX_W-1:0] live_clusters;
    logic [LENGTH_W-1:0] min_spacing;
    logic [VERTEX_W-1:0] vc_reg;
    logic [VERTEX_W-1:0] tc_reg;

    result_t expected_reports [$];   // reports owed by the block, oldest first
    edge_t   edge_queue [$];         // edges not yet offered to the block
    int      edges_queued = 0;
    int      edges_accepted = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    // Traffic shaping knobs, changed per phase
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      hold_left = 0;
    logic    hold_pulse = 1'b0;
    logic    long_hold = 1'b0;

    // Vertex counts above the store depth act as the full depth
    function automatic int live_count();
        return (vc_reg > FOREST_SIZE) ? FOREST_SIZE : int'(vc_reg);
    endfunction

    function automatic int root_of(input int node);
        int steps;
        steps = 0;
        while (steps < FOREST_SIZE)
        begin
            if (uf_parent[node] == node)
                break;
            node = uf_parent[node];
            steps++;
        end
        return node;
    endfunction

    // Back to singletons: identity parents, zero ranks, full count, spacing at start
    task automatic reset_forest();
        for (int i = 0; i < FOREST_SIZE; i++)
        begin
            uf_parent[i] = i[9:0];
            uf_rank[i]   = '0;
        end
        live_clusters = VERTEX_W'(live_count());
        min_spacing   = SPACING_START;
    endtask

    // Fold one accepted edge into the forest; a last edge owes one report
    task automatic absorb_edge(input edge_t e);
        int      n;
        int      ra;
        int      rb;
        result_t r;
        n = live_count();
        // Out-of-range endpoints leave the forest alone; the last mark still counts
        if (e.u >= 1 && e.u <= n && e.v >= 1 && e.v <= n)
        begin
            ra = root_of(int'(e.u) - 1);
            rb = root_of(int'(e.v) - 1);
            if (live_clusters > tc_reg)
            begin
                // Still merging: union by rank, nothing happens on a shared root
                if (ra != rb)
                begin
                    if (uf_rank[ra] < uf_rank[rb])
                        uf_parent[ra] = rb[9:0];
                    else if (uf_rank[ra] > uf_rank[rb])
                        uf_parent[rb] = ra[9:0];
                    else
                    begin
                        uf_parent[rb] = ra[9:0];
                        if (uf_rank[ra] < RANK_MAX)
                            uf_rank[ra] = uf_rank[ra] + 1'b1;
                    end
                    live_clusters = live_clusters - 1'b1;
                end
            end
            else if (ra != rb && e.len < min_spacing)
                min_spacing = e.len;
        end
        if (e.last)
        begin
            r.spacing  = min_spacing;
            r.clusters = live_clusters;
            expected_reports.insert(expected_reports.size(), r);
            reset_forest();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer edges from edge_queue. Hold valid and the payload
    // until the item is taken; random gaps only start once the slot is free.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : edge_driver
        edge_t nxt;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            first_vertex  <= '0;
            second_vertex <= '0;
            edge_length   <= '0;
            last_edge     <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_edge({first_vertex, second_vertex, edge_length, last_edge});
                edges_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (edge_queue.size() > 0)
                begin
                    nxt = edge_queue.pop_front();
                    first_vertex  <= nxt.u;
                    second_vertex <= nxt.v;
                    edge_length   <= nxt.len;
                    last_edge     <= nxt.last;
                    in_valid      <= 1'b1;
                    // Idle after this item for a random burst
                    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                        gap_left = $urandom_range(1, 10);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: counted here, started by a one-cycle pulse.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left = 0;
            long_hold <= 1'b0;
        end
        else
        begin
            if (hold_pulse)
                hold_left = HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left--;
            long_hold <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken report with the oldest expected one,
    // then pick the next cycle's stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        result_t want;
        logic    burst;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: max_spacing %0d final_clusters %0d",
                           max_spacing, final_clusters);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (max_spacing !== want.spacing)
                    begin
                        $error("max_spacing: expected %0d, got %0d", want.spacing, max_spacing);
                        error_count++;
                    end
                    if (final_clusters !== want.clusters)
                    begin
                        $error("final_clusters: expected %0d, got %0d",
                               want.clusters, final_clusters);
                        error_count++;
                    end
                end
            end
            burst = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                burst = 1'b1;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                burst = 1'b1;
            end
            out_stall <= burst || long_hold;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_edge(input int u, input int v, input int len, input bit last);
        edge_t e;
        e.u    = u[VERTEX_W-1:0];
        e.v    = v[VERTEX_W-1:0];
        e.len  = len[LENGTH_W-1:0];
        e.last = last;
        edge_queue.insert(edge_queue.size(), e);
        edges_queued++;
    endtask

    // Mostly in-range vertices; noisy graphs carry many arbitrary 11-bit numbers
    function automatic int pick_vertex(input int live, input bit noisy);
        if (live == 0 || $urandom_range(0, 99) < (noisy ? 40 : 3))
            return $urandom_range(0, 2047);
        return $urandom_range(1, live);
    endfunction

    // A graph whose final edge carries the last mark; lengths ascending unless noisy
    task automatic queue_graph(input int live, input int n, input bit noisy);
        int lens [$];
        int hi;
        case ($urandom_range(0, 2))
            0:       hi = 15;
            1:       hi = 1000;
            default: hi = 1048575;
        endcase
        for (int i = 0; i < n; i++)
            lens.insert(lens.size(), $urandom_range(0, hi));
        if (!noisy)
            lens.sort();
        for (int i = 0; i < n; i++)
            queue_edge(pick_vertex(live, noisy), pick_vertex(live, noisy), lens[i], i == n - 1);
    endtask

    // Wait until every edge is taken and every report is in, then let the sweep finish
    task automatic wait_drained();
        while (edges_accepted != edges_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_VERTEX_COUNT)
        begin
            vc_reg = value[VERTEX_W-1:0];
            reset_forest();
        end
        else
            tc_reg = value[VERTEX_W-1:0];
    endtask

    // Target first: a vertex_count write starts a sweep, keep the block idle for both
    task automatic set_config(input int vc, input int tc);
        wait_drained();
        write_reg(REG_TARGET_CLUSTERS, tc);
        write_reg(REG_VERTEX_COUNT, vc);
    endtask

    task automatic run_phase(input int vc, input int tc, input int budget,
                             input int sender_pct, input int receiver_pct, input bit squeeze);
        int live;
        int n;
        int hi;
        int used;
        set_config(vc, tc);
        send_idle_pct <= sender_pct;
        recv_idle_pct <= receiver_pct;
        live = (vc > FOREST_SIZE) ? FOREST_SIZE : vc;
        used = 0;
        while (used < budget)
        begin
            // Small forests get enough edges to merge down to the target and
            // then measure spacing; big ones get short graphs.
            if (live >= 2 && live <= 64)
            begin
                hi = (3 * live > 60) ? 60 : 3 * live;
                n  = $urandom_range((live < hi) ? live : hi, hi);
            end
            else
                n = $urandom_range(1, 30);
            queue_graph(live, n, $urandom_range(0, 7) == 0);
            used += n;
        end
        if (squeeze)
        begin
            // Hold the receiver while the queue is full so the block backs up
            @(posedge clk);
            hold_pulse <= 1'b1;
            @(posedge clk);
            hold_pulse <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        vc_reg = VERTEX_COUNT_RESET;
        tc_reg = TARGET_RESET;
        reset_forest();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: top vertex, vertex 0, numbers past the count and with
        // bit 10 set, a shared-root merge, length extremes, a last edge with out-of-range endpoints
        queue_edge(1, 1024, 0, 1'b0);
        queue_edge(0, 5, 3, 1'b0);
        queue_edge(1025, 2, 4, 1'b0);
        queue_edge(2047, 2047, 5, 1'b0);
        queue_edge(1024, 1, 6, 1'b0);
        queue_edge(512, 3, 1000000, 1'b0);
        queue_edge(0, 0, 1048575, 1'b1);

        // Five vertices down to two clusters: equal-rank, lower-rank and
        // higher-rank unions, a shared root, then spacing with a same-cluster
        // edge, a non-lowering edge, a self loop and a vertex past the count
        set_config(5, 2);
        queue_edge(1, 2, 1, 1'b0);
        queue_edge(2, 1, 2, 1'b0);
        queue_edge(3, 1, 3, 1'b0);
        queue_edge(1, 4, 4, 1'b0);
        queue_edge(5, 1, 7, 1'b0);
        queue_edge(2, 3, 8, 1'b0);
        queue_edge(5, 4, 9, 1'b0);
        queue_edge(5, 5, 0, 1'b0);
        queue_edge(6, 1, 1, 1'b0);
        queue_edge(0, 0, 10, 1'b1);

        // No vertices at all, target zero
        set_config(0, 0);
        queue_edge(1, 1, 0, 1'b1);

        // A single vertex: only self loops
        set_config(1, 0);
        queue_edge(1, 1, 5, 1'b0);
        queue_edge(1, 1, 2, 1'b1);

        // Oversized count acts as full depth; target above the count measures at once
        set_config(2047, 2047);
        queue_edge(1024, 1024, 0, 1'b0);
        queue_edge(3, 4, 1000001, 1'b0);
        queue_edge(1, 2, 55, 1'b1);

        // Random graphs under several settings; the first phase also runs the
        // long receiver hold-off, the last two run without idling
        run_phase($urandom_range(8, 40), $urandom_range(1, 6), 130, 30, 30, 1'b1);
        run_phase(1024, 1024, 110, 0, 0, 1'b0);
        run_phase(2, 1, 110, 50, 10, 1'b0);
        run_phase($urandom_range(3, 64), 0, 120, 20, 40, 1'b0);
        run_phase(2047, $urandom_range(0, 2047), 110, 30, 30, 1'b0);
        run_phase($urandom_range(4, 24), $urandom_range(1, 4), 120, 10, 60, 1'b0);
        run_phase($urandom_range(4, 24), $urandom_range(1, 24), 120, 0, 0, 1'b0);
        run_phase($urandom_range(4, 24), $urandom_range(1, 3), 100, 0, 0, 1'b0);

        // Drain, then leave time for any stray report to show up
        wait_drained();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
sv/ukc_pkg.sv
sv/ukc_ram.sv
sv/ukc_seq.sv
sv/union_find_kruskal_clustering_top.sv
tb/sv/union_find_kruskal_clustering_top_tb.sv
